// ----- src/itoab_pkg.sv -----
// types, constants and the digit-to-character function for the radix converter
package itoab_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 7;

  // quotient bits resolved per divider cycle, and divider steps per digit
  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd3;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_A = 7'h61;
  localparam logic [CHAR_W-1:0]  CHAR_UP_A  = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2d;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_FETCH = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UP_A : CHAR_LOW_A;
    if (d >= DIGIT_TEN) begin
      return base + CHAR_W'(d - DIGIT_TEN);
    end
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

endpackage

// ----- src/itoab_ram.sv -----
// generic single-write, single-read ram with registered read data
module itoab_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 41
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/integer_to_ascii_base.sv -----
// radix conversion of a 64-bit integer to ascii text, one character per strobe
// sequence: the shared divider resolves 8 quotient bits per cycle and writes each digit, then
//   a fetch state reads the buffer and one character per cycle is emitted, '-' first if negative
// a start is taken only while idle; busy until the last character, digit count 1 to 41
// the registered read of the digit buffer ram sets the fetch state; the receiver cannot stall results
// reset: synchronous, clears the sequencer and the strobe; the digit buffer is not cleared
module integer_to_ascii_base #(
  parameter int unsigned DIGIT_SLOTS = 41
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [itoab_pkg::VALUE_W-1:0]  value,
  input  logic                           is_signed,
  input  logic [itoab_pkg::RADIX_W-1:0]  radix,
  input  logic                           upper_case,
  output logic                           char_valid,
  output logic [itoab_pkg::CHAR_W-1:0]   ascii_char,
  output logic                           last_char
);

  import itoab_pkg::*;

  localparam int unsigned IDX_W = $clog2(DIGIT_SLOTS);
  localparam int unsigned CNT_W = $clog2(DIGIT_SLOTS + 1);

  state_t              state;
  logic [VALUE_W-1:0]  mag;
  logic [DIGIT_W-1:0]  rem;
  logic [RADIX_W-1:0]  radix_q;
  logic                upper;
  logic                negative;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    ptr;

  logic [VALUE_W-1:0]  mag_next;
  logic [DIGIT_W-1:0]  rem_next;
  logic [CNT_W-1:0]    count_next;
  logic                radix_ok;
  logic                take;
  logic                neg_in;
  logic                ram_we;
  logic [IDX_W-1:0]    raddr;
  logic [DIGIT_W-1:0]  rdata;

  assign busy     = (state != S_IDLE);
  assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign take     = start && !busy;
  assign neg_in   = is_signed && value[VALUE_W-1];

  // shared divider: eight restoring steps per cycle, msb first
  always_comb begin
    logic [VALUE_W-1:0] q;
    logic [DIGIT_W-1:0] r;
    logic [RADIX_W-1:0] trial;
    q = mag;
    r = rem;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      trial = {r, q[VALUE_W-1]};
      if (trial >= radix_q) begin
        trial = trial - radix_q;
        q = {q[VALUE_W-2:0], 1'b1};
      end else begin
        q = {q[VALUE_W-2:0], 1'b0};
      end
      r = trial[DIGIT_W-1:0];
    end
    mag_next = q;
    rem_next = r;
  end

  assign count_next = count + 1'b1;
  assign ram_we     = (state == S_DIV) && (step == STEP_W'(DIV_STEPS - 1));
  assign raddr      = (state == S_FETCH) ? ptr : ptr - 1'b1;

  itoab_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_SLOTS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (rem_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
      count      <= '0;
      negative   <= 1'b0;
      step       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          char_valid <= 1'b0;
          if (take && radix_ok) begin
            mag      <= neg_in ? VALUE_W'(0) - value : value;
            rem      <= '0;
            radix_q  <= radix;
            upper    <= upper_case;
            negative <= neg_in;
            step     <= '0;
            count    <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          char_valid <= 1'b0;
          mag        <= mag_next;
          rem        <= ram_we ? '0 : rem_next;
          step       <= step + 1'b1;
          if (ram_we) begin
            count <= count_next;
            ptr   <= count[IDX_W-1:0];
            if ((mag_next == '0) || (count_next == CNT_W'(DIGIT_SLOTS))) begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          char_valid <= negative;
          ascii_char <= CHAR_MINUS;
          last_char  <= 1'b0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          char_valid <= 1'b1;
          ascii_char <= digit_char(rdata, upper);
          last_char  <= (ptr == '0);
          if (ptr == '0) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr - 1'b1;
          end
        end
        default: begin
          char_valid <= 1'b0;
          state      <= S_IDLE;
        end
      endcase
    end
  end

endmodule
